FILE: rtl/cps_pkg.sv
package cps_pkg;

    localparam int STATE_W = 3;
    localparam int ACT_W   = 2;
    localparam int DELAY_W = 13;
    localparam int TIME_W  = 32;
    localparam int SEC_W   = 16;
    localparam int MV_W    = 16;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 32;
    // 65535 s * 1000 fits in 26 bits
    localparam int LIM_MS_W = 26;

    localparam logic [STATE_W-1:0] ST_IDLE          = 3'd0;
    localparam logic [STATE_W-1:0] ST_WAIT_STATUS   = 3'd1;
    localparam logic [STATE_W-1:0] ST_AWAKE         = 3'd2;
    localparam logic [STATE_W-1:0] ST_WAIT_SHUTDOWN = 3'd3;
    localparam logic [STATE_W-1:0] ST_STOP          = 3'd4;

    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RADIO = 2'd1;
    localparam logic [ACT_W-1:0] ACT_KEEP  = 2'd2;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [CIDX_W-1:0] REG_UV_THRESHOLD = 3'd0;
    localparam logic [CIDX_W-1:0] REG_STARTUP_TO   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_POWER_PERIOD = 3'd2;
    localparam logic [CIDX_W-1:0] REG_SHUTDOWN_TO  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_KEEP_ALIVE   = 3'd4;

    localparam logic [MV_W-1:0]   UV_THRESHOLD_RST = 16'd3300;
    localparam logic [SEC_W-1:0]  STARTUP_TO_RST   = 16'd60;
    localparam logic [SEC_W-1:0]  POWER_PERIOD_RST = 16'd1800;
    localparam logic [SEC_W-1:0]  SHUTDOWN_TO_RST  = 16'd15;
    localparam logic [TIME_W-1:0] KEEP_ALIVE_RST   = 32'd86400000;

    localparam logic [DELAY_W-1:0]  RUN_DELAY_MS = 13'd5000;
    localparam logic [LIM_MS_W-1:0] MS_PER_S     = 26'd1000;

    typedef struct packed {
        logic [MV_W-1:0]   uv_threshold_mv;
        logic [SEC_W-1:0]  startup_timeout_s;
        logic [SEC_W-1:0]  power_period_s;
        logic [SEC_W-1:0]  shutdown_timeout_s;
        logic [TIME_W-1:0] keep_alive_ms;
    } cfg_t;

    typedef struct packed {
        logic [STATE_W-1:0] machine_state;
        logic [ACT_W-1:0]   activation_source;
        logic [TIME_W-1:0]  state_entry_ms;
        logic [SEC_W-1:0]   timeout_limit_s;
        logic [STATE_W-1:0] timeout_target;
        logic [TIME_W-1:0]  last_active_ms;
        logic               power_on;
    } seq_state_t;

    typedef struct packed {
        logic               run_now;
        logic [DELAY_W-1:0] delay_ms;
        logic               lockout;
        logic               power_enable;
        logic [STATE_W-1:0] fsm_state;
        logic [ACT_W-1:0]   activation;
        logic               capture_sensors;
        logic               send_status;
    } result_t;

endpackage

FILE: rtl/cps_step.sv
module cps_step
    import cps_pkg::*;
(
    input  cfg_t               cfg,
    input  seq_state_t         cur,
    input  logic               operation,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic               status_pin,
    input  logic [MV_W-1:0]    battery_mv,
    input  logic               wake_request,
    output seq_state_t         nxt,
    output result_t            res
);

    logic                run;
    logic [DELAY_W-1:0]  dly;
    logic                lock;
    logic                cap;
    logic                snd;
    logic                moved;
    logic [TIME_W-1:0]   elapsed_ms;
    logic [TIME_W-1:0]   idle_ms;
    logic [LIM_MS_W-1:0] limit_ms;

    assign elapsed_ms = now_ms - cur.state_entry_ms;
    assign idle_ms    = now_ms - cur.last_active_ms;

    always_comb
    begin
        nxt      = cur;
        run      = 1'b0;
        dly      = '0;
        lock     = 1'b0;
        cap      = 1'b0;
        snd      = 1'b0;
        moved    = 1'b0;
        limit_ms = '0;

        if (wake_request)
        begin
            nxt.activation_source = ACT_RADIO;
        end

        if (operation == OP_QUERY)
        begin
            if (nxt.activation_source != ACT_NONE)
            begin
                if (cur.machine_state == ST_IDLE && battery_mv <= cfg.uv_threshold_mv)
                begin
                    nxt.activation_source = ACT_NONE;
                    lock = 1'b1;
                end
                else
                begin
                    run = 1'b1;
                    dly = RUN_DELAY_MS;
                end
            end
            else if (cfg.keep_alive_ms != '0 && idle_ms > cfg.keep_alive_ms)
            begin
                nxt.activation_source = ACT_KEEP;
                run = 1'b1;
            end
        end
        else
        begin
            case (cur.machine_state)
                ST_IDLE:
                begin
                    cap   = 1'b1;
                    moved = 1'b1;
                    nxt.machine_state = ST_WAIT_STATUS;
                end
                ST_WAIT_STATUS:
                begin
                    nxt.timeout_limit_s = cfg.startup_timeout_s;
                    nxt.timeout_target  = ST_STOP;
                    nxt.power_on        = 1'b1;
                    if (status_pin)
                    begin
                        snd   = 1'b1;
                        moved = 1'b1;
                        nxt.machine_state = ST_AWAKE;
                    end
                end
                ST_AWAKE:
                begin
                    nxt.timeout_limit_s = cfg.power_period_s;
                    nxt.timeout_target  = ST_STOP;
                    if (!status_pin)
                    begin
                        moved = 1'b1;
                        nxt.machine_state = ST_WAIT_SHUTDOWN;
                    end
                end
                ST_WAIT_SHUTDOWN:
                begin
                    nxt.timeout_limit_s = cfg.shutdown_timeout_s;
                    nxt.timeout_target  = ST_STOP;
                end
                ST_STOP:
                begin
                    nxt.power_on          = 1'b0;
                    nxt.activation_source = ACT_NONE;
                    nxt.last_active_ms    = now_ms;
                    moved = 1'b1;
                    nxt.machine_state = ST_IDLE;
                end
                default:
                begin
                    // unused codes fall back to idle, entry time untouched, unless the held timeout expires
                    nxt.machine_state = ST_IDLE;
                end
            endcase

            limit_ms = LIM_MS_W'(nxt.timeout_limit_s) * MS_PER_S;

            // a state entered this step skips the timeout check, so it cannot expire
            if (!moved && nxt.timeout_limit_s != '0 && elapsed_ms >= TIME_W'(limit_ms))
            begin
                moved = 1'b1;
                nxt.machine_state = nxt.timeout_target;
            end

            if (moved)
            begin
                nxt.state_entry_ms = now_ms;
            end
        end
    end

    always_comb
    begin
        res.run_now         = run;
        res.delay_ms        = dly;
        res.lockout         = lock;
        res.power_enable    = nxt.power_on;
        res.fsm_state       = nxt.machine_state;
        res.activation      = nxt.activation_source;
        res.capture_sensors = cap;
        res.send_status     = snd;
    end

endmodule

FILE: rtl/companion_power_sequencer.sv
// Channel   Direction  Handshake                 Payload
// input     in         in_valid / in_stall       operation, now_ms, status_pin,
//                                                battery_mv, wake_request
// result    out        out_valid / out_stall     run_now, delay_ms, lockout, power_enable,
//                                                fsm_state, activation, capture_sensors,
//                                                send_status
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per clock while in_stall is low. An item is evaluated in the cycle of
// its transfer; the sequencer state and the result register load at that edge,
// so the result is valid in the next cycle. The result register is the only
// buffer: in_stall rises only while it holds a result that the consumer is stalling.
// Reset brings config registers to their defaults and the sequencer to idle, supply off.
module companion_power_sequencer
    import cps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic               status_pin,
    input  logic [MV_W-1:0]    battery_mv,
    input  logic               wake_request,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               run_now,
    output logic [DELAY_W-1:0] delay_ms,
    output logic               lockout,
    output logic               power_enable,
    output logic [STATE_W-1:0] fsm_state,
    output logic [ACT_W-1:0]   activation,
    output logic               capture_sensors,
    output logic               send_status,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    res_reg;
    result_t    res_next;
    logic       out_valid_reg;
    logic       in_xfer;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_xfer   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.uv_threshold_mv    <= UV_THRESHOLD_RST;
            cfg_reg.startup_timeout_s  <= STARTUP_TO_RST;
            cfg_reg.power_period_s     <= POWER_PERIOD_RST;
            cfg_reg.shutdown_timeout_s <= SHUTDOWN_TO_RST;
            cfg_reg.keep_alive_ms      <= KEEP_ALIVE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_UV_THRESHOLD: cfg_reg.uv_threshold_mv    <= cfg_data[MV_W-1:0];
                REG_STARTUP_TO:   cfg_reg.startup_timeout_s  <= cfg_data[SEC_W-1:0];
                REG_POWER_PERIOD: cfg_reg.power_period_s     <= cfg_data[SEC_W-1:0];
                REG_SHUTDOWN_TO:  cfg_reg.shutdown_timeout_s <= cfg_data[SEC_W-1:0];
                REG_KEEP_ALIVE:   cfg_reg.keep_alive_ms      <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    cps_step u_step (
        .cfg          (cfg_reg),
        .cur          (state_reg),
        .operation    (operation),
        .now_ms       (now_ms),
        .status_pin   (status_pin),
        .battery_mv   (battery_mv),
        .wake_request (wake_request),
        .nxt          (state_next),
        .res          (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.machine_state     <= ST_IDLE;
            state_reg.activation_source <= ACT_NONE;
            state_reg.state_entry_ms    <= '0;
            state_reg.timeout_limit_s   <= '0;
            state_reg.timeout_target    <= ST_IDLE;
            state_reg.last_active_ms    <= '0;
            state_reg.power_on          <= 1'b0;
            out_valid_reg               <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign run_now         = res_reg.run_now;
    assign delay_ms        = res_reg.delay_ms;
    assign lockout         = res_reg.lockout;
    assign power_enable    = res_reg.power_enable;
    assign fsm_state       = res_reg.fsm_state;
    assign activation      = res_reg.activation;
    assign capture_sensors = res_reg.capture_sensors;
    assign send_status     = res_reg.send_status;

endmodule
